>>> sv/cds_pkg.sv
// Shared types and constants for the chunk distance sorter.
`default_nettype none
package cds_pkg;

  localparam int MAX_ENTRIES = 512;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int COORD_W     = 12;
  localparam int FOCAL_W     = 20;
  localparam int DIFF_W      = 22;
  localparam int SQ_W        = 40;
  localparam int SUM_W       = 42;
  localparam int KEY_W       = 38;
  localparam int TAG_W       = 9;
  localparam int DIST_W      = 48;
  localparam int OCC_W       = 10;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    REG_FOCAL_X = 2'd0,
    REG_FOCAL_Y = 2'd1,
    REG_FOCAL_Z = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t new_entry;
  } cell_op_t;

  typedef struct packed {
    logic in_list;
    logic is_tail;
  } cell_pos_t;

endpackage
`default_nettype wire

>>> sv/cds_key_unit.sv
// Two-stage pipeline that turns a chunk coordinate into its squared distance key.
`default_nettype none
module cds_key_unit (
  input  wire logic                          clk,
  input  wire logic [cds_pkg::FOCAL_W-1:0]   focal_x,
  input  wire logic [cds_pkg::FOCAL_W-1:0]   focal_y,
  input  wire logic [cds_pkg::FOCAL_W-1:0]   focal_z,
  input  wire logic [cds_pkg::COORD_W-1:0]   chunk_x,
  input  wire logic [cds_pkg::COORD_W-1:0]   chunk_y,
  input  wire logic [cds_pkg::COORD_W-1:0]   chunk_z,
  output logic      [cds_pkg::KEY_W-1:0]     key
);

  logic signed [cds_pkg::DIFF_W-1:0]   dx, dy, dz;
  logic signed [2*cds_pkg::DIFF_W-1:0] px, py, pz;
  logic        [cds_pkg::SQ_W-1:0]     sqx_r, sqy_r, sqz_r;
  logic        [cds_pkg::SUM_W-1:0]    sum;
  logic        [cds_pkg::KEY_W-1:0]    key_r;

  // The centre on an axis is 256 * c + 128, which is the coordinate followed by 8'h80.
  assign dx = $signed(cds_pkg::DIFF_W'($signed(focal_x)))
            - $signed(cds_pkg::DIFF_W'($signed({chunk_x, 8'h80})));
  assign dy = $signed(cds_pkg::DIFF_W'($signed(focal_y)))
            - $signed(cds_pkg::DIFF_W'($signed({chunk_y, 8'h80})));
  assign dz = $signed(cds_pkg::DIFF_W'($signed(focal_z)))
            - $signed(cds_pkg::DIFF_W'($signed({chunk_z, 8'h80})));

  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;

  assign sum = cds_pkg::SUM_W'(sqx_r) + cds_pkg::SUM_W'(sqy_r) + cds_pkg::SUM_W'(sqz_r)
             + cds_pkg::SUM_W'(8);

  always_ff @(posedge clk) begin
    sqx_r <= px[cds_pkg::SQ_W-1:0];
    sqy_r <= py[cds_pkg::SQ_W-1:0];
    sqz_r <= pz[cds_pkg::SQ_W-1:0];
    key_r <= sum[cds_pkg::SUM_W-1:4];
  end

  assign key = key_r;

endmodule
`default_nettype wire

>>> sv/cds_cell.sv
// One slot of the sorted list, trading entries with its two neighbors.
`default_nettype none
module cds_cell (
  input  wire logic              clk,
  input  wire cds_pkg::cell_op_t op,
  input  wire cds_pkg::cell_pos_t pos,
  input  wire cds_pkg::entry_t   left_entry,
  input  wire logic              left_gt,
  input  wire cds_pkg::entry_t   right_entry,
  output cds_pkg::entry_t        entry,
  output logic                   gt
);

  cds_pkg::entry_t entry_r;
  cds_pkg::entry_t entry_nxt;

  assign gt = pos.in_list && (entry_r.key > op.new_entry.key);

  always_comb begin
    entry_nxt = entry_r;
    if (op.ins) begin
      if (left_gt) begin
        entry_nxt = left_entry;
      end else if (gt || pos.is_tail) begin
        entry_nxt = op.new_entry;
      end
    end else if (op.pop) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule
`default_nettype wire

>>> sv/chunk_distance_sorter_core.sv
// Top level of the chunk distance sorter: control, configuration port and the cell row.
// A load runs from its accepting edge through the SQUARE, SUM and EXEC states, set by the
// two registered stages of the key unit and the insert step in the cell row; a pop, a clear
// or an unused mode runs through EXEC alone. The result is on the out_ ports for one cycle,
// the cycle in which busy falls, and the receiver cannot stall it. Every item gives exactly
// one result. The list holds up to 512 entries, and a reset or a clear empties it at once.
`default_nettype none
module chunk_distance_sorter_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    in_mode,
  input  wire logic [cds_pkg::COORD_W-1:0]   in_chunk_x,
  input  wire logic [cds_pkg::COORD_W-1:0]   in_chunk_y,
  input  wire logic [cds_pkg::COORD_W-1:0]   in_chunk_z,
  input  wire logic [cds_pkg::TAG_W-1:0]     in_chunk_tag,
  output logic                               out_valid,
  output logic      [cds_pkg::TAG_W-1:0]     out_tag,
  output logic      [cds_pkg::DIST_W-1:0]    out_distance,
  output logic                               out_found,
  output logic                               out_dropped,
  output logic      [cds_pkg::OCC_W-1:0]     out_occupancy,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cds_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [cds_pkg::DATA_W-1:0]    pwdata,
  output logic      [cds_pkg::DATA_W-1:0]    prdata,
  output logic                               pready
);

  localparam int N = cds_pkg::MAX_ENTRIES;

  cds_pkg::state_t state_r, state_nxt;

  logic [1:0]                  mode_r;
  logic [cds_pkg::COORD_W-1:0] chunk_x_r, chunk_y_r, chunk_z_r;
  logic [cds_pkg::TAG_W-1:0]   tag_r;
  logic [cds_pkg::FOCAL_W-1:0] focal_x_r, focal_y_r, focal_z_r;
  logic [cds_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [cds_pkg::KEY_W-1:0]   key;

  logic                        out_valid_r;
  logic [cds_pkg::TAG_W-1:0]   out_tag_r, out_tag_nxt;
  logic [cds_pkg::KEY_W-1:0]   out_key_r, out_key_nxt;
  logic                        out_found_r, out_found_nxt;
  logic                        out_dropped_r, out_dropped_nxt;
  logic [cds_pkg::CNT_W-1:0]   out_count_r;

  logic accept, exec, full, empty, cfg_write;
  cds_pkg::cell_op_t op;

  cds_pkg::entry_t cell_entry [N];
  logic            cell_gt    [N];

  assign accept    = start && !busy;
  assign exec      = (state_r == cds_pkg::ST_EXEC);
  assign full      = (count_r == cds_pkg::CNT_W'(N));
  assign empty     = (count_r == '0);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cds_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_mode == cds_pkg::MODE_LOAD) ? cds_pkg::ST_SQUARE : cds_pkg::ST_EXEC;
        end
      end
      cds_pkg::ST_SQUARE: state_nxt = cds_pkg::ST_SUM;
      cds_pkg::ST_SUM:    state_nxt = cds_pkg::ST_EXEC;
      cds_pkg::ST_EXEC:   state_nxt = cds_pkg::ST_IDLE;
      default:            state_nxt = cds_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy             = (state_r != cds_pkg::ST_IDLE);
    op.ins           = exec && (mode_r == cds_pkg::MODE_LOAD) && !full;
    op.pop           = exec && (mode_r == cds_pkg::MODE_POP) && !empty;
    op.new_entry.key = key;
    op.new_entry.tag = tag_r;
  end

  always_comb begin
    count_nxt       = count_r;
    out_tag_nxt     = '0;
    out_key_nxt     = '0;
    out_found_nxt   = 1'b0;
    out_dropped_nxt = 1'b0;
    if (exec) begin
      case (mode_r)
        cds_pkg::MODE_LOAD: begin
          if (full) begin
            out_dropped_nxt = 1'b1;
          end else begin
            count_nxt = count_r + cds_pkg::CNT_W'(1);
          end
        end
        cds_pkg::MODE_POP: begin
          if (!empty) begin
            out_found_nxt = 1'b1;
            out_tag_nxt   = cell_entry[0].tag;
            out_key_nxt   = cell_entry[0].key;
            count_nxt     = count_r - cds_pkg::CNT_W'(1);
          end
        end
        cds_pkg::MODE_CLEAR: count_nxt = '0;
        default: count_nxt = count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cds_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      focal_x_r   <= '0;
      focal_y_r   <= '0;
      focal_z_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= exec;
      if (cfg_write) begin
        unique case (paddr[3:2])
          cds_pkg::REG_FOCAL_X: focal_x_r <= pwdata[cds_pkg::FOCAL_W-1:0];
          cds_pkg::REG_FOCAL_Y: focal_y_r <= pwdata[cds_pkg::FOCAL_W-1:0];
          cds_pkg::REG_FOCAL_Z: focal_z_r <= pwdata[cds_pkg::FOCAL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r    <= in_mode;
      chunk_x_r <= in_chunk_x;
      chunk_y_r <= in_chunk_y;
      chunk_z_r <= in_chunk_z;
      tag_r     <= in_chunk_tag;
    end
    if (exec) begin
      out_tag_r     <= out_tag_nxt;
      out_key_r     <= out_key_nxt;
      out_found_r   <= out_found_nxt;
      out_dropped_r <= out_dropped_nxt;
      out_count_r   <= count_nxt;
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      cds_pkg::REG_FOCAL_X: prdata = cds_pkg::DATA_W'(focal_x_r);
      cds_pkg::REG_FOCAL_Y: prdata = cds_pkg::DATA_W'(focal_y_r);
      cds_pkg::REG_FOCAL_Z: prdata = cds_pkg::DATA_W'(focal_z_r);
      default:              prdata = '0;
    endcase
  end

  cds_key_unit u_key (
    .clk     (clk),
    .focal_x (focal_x_r),
    .focal_y (focal_y_r),
    .focal_z (focal_z_r),
    .chunk_x (chunk_x_r),
    .chunk_y (chunk_y_r),
    .chunk_z (chunk_z_r),
    .key     (key)
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    cds_pkg::cell_pos_t pos;
    cds_pkg::entry_t    left_entry;
    cds_pkg::entry_t    right_entry;
    logic               left_gt;

    assign pos.in_list = (cds_pkg::CNT_W'(i) < count_r);
    assign pos.is_tail = (cds_pkg::CNT_W'(i) == count_r);

    if (i == 0) begin : g_first
      assign left_entry = '0;
      assign left_gt    = 1'b0;
    end else begin : g_inner
      assign left_entry = cell_entry[i-1];
      assign left_gt    = cell_gt[i-1];
    end

    if (i == N - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_more
      assign right_entry = cell_entry[i+1];
    end

    cds_cell u_cell (
      .clk         (clk),
      .op          (op),
      .pos         (pos),
      .left_entry  (left_entry),
      .left_gt     (left_gt),
      .right_entry (right_entry),
      .entry       (cell_entry[i]),
      .gt          (cell_gt[i])
    );
  end

  assign out_valid     = out_valid_r;
  assign out_tag       = out_tag_r;
  assign out_distance  = cds_pkg::DIST_W'(out_key_r);
  assign out_found     = out_found_r;
  assign out_dropped   = out_dropped_r;
  assign out_occupancy = cds_pkg::OCC_W'(out_count_r);

endmodule
`default_nettype wire

>>> sv/cds_checker.sv
// Port-level checks for the chunk distance sorter and the bind that attaches them.
`default_nettype none
module cds_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        out_valid,
  input wire logic [cds_pkg::TAG_W-1:0]   out_tag,
  input wire logic [cds_pkg::DIST_W-1:0]  out_distance,
  input wire logic                        out_found,
  input wire logic                        out_dropped,
  input wire logic [cds_pkg::OCC_W-1:0]   out_occupancy
);

  // An accepted request keeps the block busy until its result has been produced.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results in consecutive cycles");

  a_idle_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped |->
      out_occupancy == cds_pkg::OCC_W'(cds_pkg::MAX_ENTRIES) && !out_found)
    else $error("dropped load without a full list");

  a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_tag == '0 && out_distance == '0)
    else $error("nonzero payload without a popped entry");

endmodule

bind chunk_distance_sorter_core cds_checker u_cds_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_tag       (out_tag),
  .out_distance  (out_distance),
  .out_found     (out_found),
  .out_dropped   (out_dropped),
  .out_occupancy (out_occupancy)
);
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the chunk distance sorter: stimulus, sorted-list predictor, checks.
`timescale 1ns / 100ps
module tb_top;

  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  localparam logic [1:0] REG_UNMAPPED = 2'd3;
  localparam logic [cds_pkg::DIST_W-1:0] KEY_NEAR      = 48'd3072;
  localparam logic [cds_pkg::DIST_W-1:0] KEY_TWO_FAR   = 48'd34342964224;
  localparam logic [cds_pkg::DIST_W-1:0] KEY_THREE_FAR = 48'd51514444800;
  localparam logic [cds_pkg::FOCAL_W-1:0] FOCAL_MAX = 20'h7FFFF;
  localparam logic [cds_pkg::FOCAL_W-1:0] FOCAL_MIN = 20'h80000;

  typedef struct packed {
    logic [1:0]                  mode;
    logic [cds_pkg::COORD_W-1:0] cx;
    logic [cds_pkg::COORD_W-1:0] cy;
    logic [cds_pkg::COORD_W-1:0] cz;
    logic [cds_pkg::TAG_W-1:0]   tag;
  } request_t;

  typedef struct packed {
    logic [cds_pkg::TAG_W-1:0]  tag;
    logic [cds_pkg::DIST_W-1:0] distance;
    logic                       found;
    logic                       dropped;
    logic [cds_pkg::OCC_W-1:0]  occ;
  } result_t;

  typedef struct {
    logic [cds_pkg::DIST_W-1:0] key;
    logic [cds_pkg::TAG_W-1:0]  tag;
  } held_chunk_t;

  typedef struct {
    request_t req;
    bit       typed;
    result_t  want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_mode = 2'd0;
  logic [cds_pkg::COORD_W-1:0] in_chunk_x = '0;
  logic [cds_pkg::COORD_W-1:0] in_chunk_y = '0;
  logic [cds_pkg::COORD_W-1:0] in_chunk_z = '0;
  logic [cds_pkg::TAG_W-1:0] in_chunk_tag = '0;
  logic out_valid;
  logic [cds_pkg::TAG_W-1:0] out_tag;
  logic [cds_pkg::DIST_W-1:0] out_distance;
  logic out_found;
  logic out_dropped;
  logic [cds_pkg::OCC_W-1:0] out_occupancy;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [cds_pkg::ADDR_W-1:0] paddr = '0;
  logic [cds_pkg::DATA_W-1:0] pwdata = '0;
  logic [cds_pkg::DATA_W-1:0] prdata;
  logic pready;

  logic signed [cds_pkg::FOCAL_W-1:0] focal_x = '0;
  logic signed [cds_pkg::FOCAL_W-1:0] focal_y = '0;
  logic signed [cds_pkg::FOCAL_W-1:0] focal_z = '0;
  held_chunk_t sorted_chunks[$];
  result_t pending_results[$];
  bit gaps_enabled = 1'b1;
  int failures = 0;
  int n_requests = 0;
  int n_results = 0;
  int n_found = 0;
  int n_dropped = 0;
  int n_focal_sets = 0;

  stim_row_t dir_rows [21] = '{
    '{'{cds_pkg::MODE_POP, 12'h000, 12'h000, 12'h000, 9'h000}, 1'b1,
      '{9'h000, 48'd0, 1'b0, 1'b0, 10'd0}},
    '{'{MODE_UNUSED, 12'h000, 12'h000, 12'h000, 9'h000}, 1'b1,
      '{9'h000, 48'd0, 1'b0, 1'b0, 10'd0}},
    '{'{cds_pkg::MODE_CLEAR, 12'h000, 12'h000, 12'h000, 9'h000}, 1'b1,
      '{9'h000, 48'd0, 1'b0, 1'b0, 10'd0}},
    '{'{cds_pkg::MODE_LOAD, 12'h000, 12'h000, 12'h000, 9'h000}, 1'b1,
      '{9'h000, 48'd0, 1'b0, 1'b0, 10'd1}},
    '{'{cds_pkg::MODE_LOAD, 12'h7FF, 12'h7FF, 12'h7FF, 9'h1FF}, 1'b1,
      '{9'h000, 48'd0, 1'b0, 1'b0, 10'd2}},
    '{'{cds_pkg::MODE_LOAD, 12'h800, 12'h800, 12'h800, 9'h155}, 1'b1,
      '{9'h000, 48'd0, 1'b0, 1'b0, 10'd3}},
    '{'{cds_pkg::MODE_LOAD, 12'hFFF, 12'hFFF, 12'hFFF, 9'h001}, 1'b1,
      '{9'h000, 48'd0, 1'b0, 1'b0, 10'd4}},
    '{'{cds_pkg::MODE_LOAD, 12'h800, 12'h7FF, 12'h000, 9'h0AA}, 1'b1,
      '{9'h000, 48'd0, 1'b0, 1'b0, 10'd5}},
    '{'{MODE_UNUSED, 12'hABC, 12'h123, 12'hFFF, 9'h1FF}, 1'b1,
      '{9'h000, 48'd0, 1'b0, 1'b0, 10'd5}},
    '{'{cds_pkg::MODE_POP, 12'h000, 12'h000, 12'h000, 9'h000}, 1'b1,
      '{9'h000, KEY_NEAR, 1'b1, 1'b0, 10'd4}},
    '{'{cds_pkg::MODE_POP, 12'h000, 12'h000, 12'h000, 9'h000}, 1'b1,
      '{9'h001, KEY_NEAR, 1'b1, 1'b0, 10'd3}},
    '{'{cds_pkg::MODE_POP, 12'h000, 12'h000, 12'h000, 9'h000}, 1'b1,
      '{9'h0AA, KEY_TWO_FAR, 1'b1, 1'b0, 10'd2}},
    '{'{cds_pkg::MODE_POP, 12'h000, 12'h000, 12'h000, 9'h000}, 1'b1,
      '{9'h1FF, KEY_THREE_FAR, 1'b1, 1'b0, 10'd1}},
    '{'{cds_pkg::MODE_POP, 12'h000, 12'h000, 12'h000, 9'h000}, 1'b1,
      '{9'h155, KEY_THREE_FAR, 1'b1, 1'b0, 10'd0}},
    '{'{cds_pkg::MODE_POP, 12'h000, 12'h000, 12'h000, 9'h000}, 1'b1,
      '{9'h000, 48'd0, 1'b0, 1'b0, 10'd0}},
    '{'{cds_pkg::MODE_LOAD, 12'h555, 12'hAAA, 12'h555, 9'h0F0}, 1'b1,
      '{9'h000, 48'd0, 1'b0, 1'b0, 10'd1}},
    '{'{cds_pkg::MODE_LOAD, 12'hAAA, 12'h555, 12'hAAA, 9'h10F}, 1'b1,
      '{9'h000, 48'd0, 1'b0, 1'b0, 10'd2}},
    '{'{cds_pkg::MODE_POP, 12'h000, 12'h000, 12'h000, 9'h000}, 1'b0,
      '{9'h000, 48'd0, 1'b0, 1'b0, 10'd0}},
    '{'{cds_pkg::MODE_CLEAR, 12'h000, 12'h000, 12'h000, 9'h000}, 1'b1,
      '{9'h000, 48'd0, 1'b0, 1'b0, 10'd0}},
    '{'{cds_pkg::MODE_POP, 12'h000, 12'h000, 12'h000, 9'h000}, 1'b1,
      '{9'h000, 48'd0, 1'b0, 1'b0, 10'd0}},
    '{'{cds_pkg::MODE_LOAD, 12'h7FF, 12'h800, 12'h123, 9'h1E1}, 1'b1,
      '{9'h000, 48'd0, 1'b0, 1'b0, 10'd1}}
  };

  chunk_distance_sorter_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_chunk_x(in_chunk_x), .in_chunk_y(in_chunk_y),
    .in_chunk_z(in_chunk_z), .in_chunk_tag(in_chunk_tag),
    .out_valid(out_valid), .out_tag(out_tag), .out_distance(out_distance),
    .out_found(out_found), .out_dropped(out_dropped), .out_occupancy(out_occupancy),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint axis_square_dist(logic signed [cds_pkg::FOCAL_W-1:0] f,
                                              logic signed [cds_pkg::COORD_W-1:0] c);
    longint d;
    d = longint'(f) - (longint'(c) * 256 + 128);
    return d * d;
  endfunction

  function automatic result_t apply_request(request_t r);
    result_t res;
    held_chunk_t chunk;
    longint unsigned sum;
    int pos;
    res = '0;
    case (r.mode)
      cds_pkg::MODE_LOAD: begin
        if (sorted_chunks.size() >= cds_pkg::MAX_ENTRIES) begin
          res.dropped = 1'b1;
        end else begin
          sum = axis_square_dist(focal_x, r.cx) + axis_square_dist(focal_y, r.cy) +
                axis_square_dist(focal_z, r.cz);
          chunk.key = cds_pkg::DIST_W'((sum + 8) >> 4);
          chunk.tag = r.tag;
          pos = sorted_chunks.size();
          while (pos > 0 && sorted_chunks[pos-1].key > chunk.key) pos--;
          sorted_chunks.insert(pos, chunk);
        end
      end
      cds_pkg::MODE_POP: begin
        if (sorted_chunks.size() > 0) begin
          chunk = sorted_chunks.pop_front();
          res.found = 1'b1;
          res.tag = chunk.tag;
          res.distance = chunk.key;
        end
      end
      cds_pkg::MODE_CLEAR: begin
        sorted_chunks.delete();
      end
      default: begin
      end
    endcase
    res.occ = cds_pkg::OCC_W'(sorted_chunks.size());
    return res;
  endfunction

  function automatic logic [cds_pkg::COORD_W-1:0] random_coord();
    if ($urandom_range(4) == 0) begin
      case ($urandom_range(3))
        0: return 12'h800;
        1: return 12'h7FF;
        2: return 12'h000;
        default: return 12'hFFF;
      endcase
    end
    return cds_pkg::COORD_W'($urandom);
  endfunction

  function automatic request_t random_request(int load_pct, int pop_pct, int clear_pct);
    request_t r;
    int roll;
    roll = $urandom_range(99);
    if (roll < load_pct) r.mode = cds_pkg::MODE_LOAD;
    else if (roll < load_pct + pop_pct) r.mode = cds_pkg::MODE_POP;
    else if (roll < load_pct + pop_pct + clear_pct) r.mode = cds_pkg::MODE_CLEAR;
    else r.mode = MODE_UNUSED;
    r.cx = random_coord();
    r.cy = random_coord();
    r.cz = random_coord();
    r.tag = cds_pkg::TAG_W'($urandom);
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(request_t r, bit typed, result_t typed_want);
    result_t predicted;
    if (gaps_enabled && $urandom_range(99) < 8) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    start <= 1'b1;
    in_mode <= r.mode;
    in_chunk_x <= r.cx;
    in_chunk_y <= r.cy;
    in_chunk_z <= r.cz;
    in_chunk_tag <= r.tag;
    do @(posedge clk); while (busy);
    predicted = apply_request(r);
    pending_results.push_back(typed ? typed_want : predicted);
    n_requests++;
    @(negedge clk);
  endtask

  task automatic run_random(int count, int load_pct, int pop_pct, int clear_pct);
    repeat (count) send_request(random_request(load_pct, pop_pct, clear_pct), 1'b0, '0);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [cds_pkg::FOCAL_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {12'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      cds_pkg::REG_FOCAL_X: focal_x = value;
      cds_pkg::REG_FOCAL_Y: focal_y = value;
      cds_pkg::REG_FOCAL_Z: focal_z = value;
      default: begin
      end
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_focal(logic [cds_pkg::FOCAL_W-1:0] fx, logic [cds_pkg::FOCAL_W-1:0] fy,
                           logic [cds_pkg::FOCAL_W-1:0] fz);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    write_reg(cds_pkg::REG_FOCAL_X, fx);
    write_reg(cds_pkg::REG_FOCAL_Y, fy);
    write_reg(REG_UNMAPPED, cds_pkg::FOCAL_W'($urandom));
    write_reg(cds_pkg::REG_FOCAL_Z, fz);
    n_focal_sets++;
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: tag %0h distance %0d occupancy %0d",
               out_tag, out_distance, out_occupancy);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (want.found) n_found++;
        if (want.dropped) n_dropped++;
        if (out_tag !== want.tag) begin
          $error("out_tag: expected %0h, got %0h", want.tag, out_tag);
          failures++;
        end
        if (out_distance !== want.distance) begin
          $error("out_distance: expected %0d, got %0d", want.distance, out_distance);
          failures++;
        end
        if (out_found !== want.found) begin
          $error("out_found: expected %0b, got %0b", want.found, out_found);
          failures++;
        end
        if (out_dropped !== want.dropped) begin
          $error("out_dropped: expected %0b, got %0b", want.dropped, out_dropped);
          failures++;
        end
        if (out_occupancy !== want.occ) begin
          $error("out_occupancy: expected %0d, got %0d", want.occ, out_occupancy);
          failures++;
        end
      end
    end
  end

  initial begin : stimulus
    int i;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    set_focal('0, '0, '0);
    for (i = 0; i < $size(dir_rows); i++) begin
      send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
    end

    set_focal(FOCAL_MAX, FOCAL_MIN, cds_pkg::FOCAL_W'($urandom));
    run_random(40, 55, 35, 3);

    set_focal(cds_pkg::FOCAL_W'($urandom), cds_pkg::FOCAL_W'($urandom),
              cds_pkg::FOCAL_W'($urandom));
    gaps_enabled = 1'b0;
    run_random(40, 80, 15, 0);
    gaps_enabled = 1'b1;
    run_random(20, 80, 15, 0);

    // Fill the list to capacity, then push against the full list.
    set_focal(FOCAL_MIN, FOCAL_MIN, FOCAL_MIN);
    while (sorted_chunks.size() < cds_pkg::MAX_ENTRIES) run_random(1, 100, 0, 0);
    run_random(6, 100, 0, 0);
    run_random(1, 0, 100, 0);
    run_random(2, 100, 0, 0);
    run_random(30, 25, 70, 1);

    set_focal(FOCAL_MAX, FOCAL_MAX, FOCAL_MAX);
    run_random(20, 50, 40, 5);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Run covered %0d requests over %0d focal settings, %0d results checked.",
             n_requests, n_focal_sets, n_results);
    $display("Pops that returned an entry: %0d; loads refused on a full list: %0d.",
             n_found, n_dropped);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("Verification failed");
    $finish;
  end

endmodule
